FILE: rtl/pl0_pkg.sv
package pl0_pkg;

    localparam int WORD_W      = 32;
    localparam int CODE_W      = 11;
    localparam int ADDR_W      = 12;
    localparam int TOP_W       = ADDR_W + 1;
    localparam int LEV_W       = 2;
    localparam int KIND_W      = 3;
    localparam int STACK_DEPTH = 2 ** ADDR_W;
    localparam int DCNT_W      = $clog2(WORD_W + 1);

    typedef enum logic [KIND_W-1:0] {
        K_LIT = 3'd0,
        K_OPR = 3'd1,
        K_LOD = 3'd2,
        K_STO = 3'd3,
        K_CAL = 3'd4,
        K_INT = 3'd5,
        K_JMP = 3'd6,
        K_JPC = 3'd7
    } t_kind;

    localparam logic [CODE_W-1:0] OPR_RET = 11'd0;
    localparam logic [CODE_W-1:0] OPR_NEG = 11'd1;
    localparam logic [CODE_W-1:0] OPR_ADD = 11'd2;
    localparam logic [CODE_W-1:0] OPR_SUB = 11'd3;
    localparam logic [CODE_W-1:0] OPR_MUL = 11'd4;
    localparam logic [CODE_W-1:0] OPR_DIV = 11'd5;
    localparam logic [CODE_W-1:0] OPR_ODD = 11'd6;
    localparam logic [CODE_W-1:0] OPR_EQ  = 11'd8;
    localparam logic [CODE_W-1:0] OPR_NE  = 11'd9;
    localparam logic [CODE_W-1:0] OPR_LT  = 11'd10;
    localparam logic [CODE_W-1:0] OPR_GE  = 11'd11;
    localparam logic [CODE_W-1:0] OPR_GT  = 11'd12;
    localparam logic [CODE_W-1:0] OPR_LE  = 11'd13;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_DIV0  = 2'd1;
    localparam logic [1:0] STS_RANGE = 2'd2;

    typedef enum logic [1:0] {
        OC_NONE,
        OC_RET,
        OC_UNARY,
        OC_BINARY
    } t_opr_cls;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_LINK,
        S_LINK_WT,
        S_RD_A,
        S_WT_A,
        S_RD_B,
        S_WT_B,
        S_EXEC,
        S_DIV,
        S_WR_A,
        S_WR_B,
        S_WR_C,
        S_COMMIT,
        S_FAULT,
        S_FIN_RD,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        A_TOP,
        A_TOP_M1,
        A_TOP_P1,
        A_TOP_P2,
        A_TOP_P3,
        A_LINK,
        A_LINK_OFF,
        A_BP_P1,
        A_BP_P2,
        A_CLR
    } t_asel;

    typedef enum logic [2:0] {
        W_ZERO,
        W_OPD,
        W_X,
        W_RES,
        W_LINK,
        W_BP,
        W_SEQ
    } t_wsel;

    typedef struct packed {
        logic  in_ready;
        logic  accept;
        logic  mem_rd;
        logic  mem_wr;
        t_asel asel;
        t_wsel wsel;
        logic  cap_x;
        logic  cap_y;
        logic  link_step;
        logic  exec;
        logic  div_take;
        logic  commit;
        logic  fault;
        logic  out_load;
        logic  clr_step;
    } t_cmd;

    typedef struct packed {
        logic              in_valid;
        t_kind             kind;
        logic [CODE_W-1:0] opd;
        logic              pre_fault;
        logic              cnt_zero;
        logic              rd_bad;
        logic              addr_bad;
        logic              x_zero;
        logic              div_done;
        logic              clr_last;
        logic              out_free;
        logic              top_neg;
    } t_sts;

    function automatic t_opr_cls opr_class(input logic [CODE_W-1:0] f);
        t_opr_cls c;
        case (f) inside
            OPR_RET:                                   c = OC_RET;
            OPR_NEG, OPR_ODD:                          c = OC_UNARY;
            [OPR_ADD:OPR_DIV], [OPR_EQ:OPR_LE]:        c = OC_BINARY;
            default:                                   c = OC_NONE;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/pl0_if.sv
interface pl0_in_if import pl0_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [LEV_W-1:0]  level;
    logic [CODE_W-1:0] operand;

    modport source (output valid, kind, level, operand, input ready);
    modport sink   (input valid, kind, level, operand, output ready);
endinterface

interface pl0_out_if import pl0_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CODE_W-1:0]        next_pc;
    logic [ADDR_W-1:0]        base_ptr;
    logic signed [TOP_W-1:0]  top_index;
    logic signed [WORD_W-1:0] top_value;
    logic                     halted;
    logic [1:0]               status;

    modport source (output valid, next_pc, base_ptr, top_index, top_value, halted, status,
                    input ready);
    modport sink   (input valid, next_pc, base_ptr, top_index, top_value, halted, status,
                    output ready);
endinterface

FILE: rtl/pl0_ctrl.sv
module pl0_ctrl import pl0_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state   r_state;
    t_state   n_state;
    t_opr_cls cls;
    logic     is_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        cls     = opr_class(i_sts.opd);
        is_div  = (i_sts.opd == OPR_DIV);
        case (r_state)
            S_CLEAR: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.asel     = A_CLR;
                o_cmd.wsel     = W_ZERO;
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.pre_fault) begin
                    n_state = S_FAULT;
                end else begin
                    case (i_sts.kind)
                        K_LIT:                 n_state = S_WR_A;
                        K_OPR:                 n_state = (cls == OC_NONE) ? S_COMMIT : S_RD_A;
                        K_LOD, K_STO, K_CAL:   n_state = S_LINK;
                        K_JPC:                 n_state = S_RD_A;
                        default:               n_state = S_COMMIT;
                    endcase
                end
            end
            S_LINK: begin
                if (i_sts.cnt_zero) begin
                    if (i_sts.kind == K_CAL) begin
                        n_state = S_WR_A;
                    end else if (i_sts.addr_bad) begin
                        n_state = S_FAULT;
                    end else begin
                        n_state = S_RD_A;
                    end
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.asel   = A_LINK;
                    n_state      = S_LINK_WT;
                end
            end
            S_LINK_WT: begin
                if (i_sts.rd_bad) begin
                    n_state = S_FAULT;
                end else begin
                    o_cmd.link_step = 1'b1;
                    n_state         = S_LINK;
                end
            end
            S_RD_A: begin
                o_cmd.mem_rd = 1'b1;
                case (i_sts.kind)
                    K_OPR:   o_cmd.asel = (cls == OC_RET) ? A_BP_P1 : A_TOP;
                    K_LOD:   o_cmd.asel = A_LINK_OFF;
                    default: o_cmd.asel = A_TOP;
                endcase
                n_state = S_WT_A;
            end
            S_WT_A: begin
                if (i_sts.kind == K_OPR && cls == OC_RET && i_sts.rd_bad) begin
                    n_state = S_FAULT;
                end else begin
                    o_cmd.cap_x = 1'b1;
                    case (i_sts.kind)
                        K_OPR:        n_state = (cls == OC_UNARY) ? S_EXEC : S_RD_B;
                        K_LOD, K_STO: n_state = S_WR_A;
                        default:      n_state = S_COMMIT;
                    endcase
                end
            end
            S_RD_B: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.asel   = (cls == OC_RET) ? A_BP_P2 : A_TOP_M1;
                n_state      = S_WT_B;
            end
            S_WT_B: begin
                o_cmd.cap_y = 1'b1;
                n_state     = (cls == OC_RET) ? S_COMMIT : S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = (is_div && !i_sts.x_zero) ? S_DIV : S_WR_A;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_WR_A;
                end
            end
            S_WR_A: begin
                o_cmd.mem_wr = 1'b1;
                case (i_sts.kind)
                    K_LIT: begin
                        o_cmd.asel = A_TOP_P1;
                        o_cmd.wsel = W_OPD;
                    end
                    K_LOD: begin
                        o_cmd.asel = A_TOP_P1;
                        o_cmd.wsel = W_X;
                    end
                    K_STO: begin
                        o_cmd.asel = A_LINK_OFF;
                        o_cmd.wsel = W_X;
                    end
                    K_CAL: begin
                        o_cmd.asel = A_TOP_P1;
                        o_cmd.wsel = W_LINK;
                    end
                    default: begin
                        o_cmd.asel = (cls == OC_UNARY) ? A_TOP : A_TOP_M1;
                        o_cmd.wsel = W_RES;
                    end
                endcase
                n_state = (i_sts.kind == K_CAL) ? S_WR_B : S_COMMIT;
            end
            S_WR_B: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.asel   = A_TOP_P2;
                o_cmd.wsel   = W_BP;
                n_state      = S_WR_C;
            end
            S_WR_C: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.asel   = A_TOP_P3;
                o_cmd.wsel   = W_SEQ;
                n_state      = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_FIN_RD;
            end
            S_FAULT: begin
                o_cmd.fault = 1'b1;
                n_state     = S_FIN_RD;
            end
            S_FIN_RD: begin
                o_cmd.mem_rd = !i_sts.top_neg;
                o_cmd.asel   = A_TOP;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: rtl/pl0_dpath.sv
module pl0_dpath import pl0_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pl0_in_if.sink       i_in,
    pl0_out_if.source    o_out,
    input  t_cmd         i_cmd,
    output t_sts         o_sts
);

    logic [WORD_W-1:0]        mem [STACK_DEPTH];
    logic [WORD_W-1:0]        r_rd;

    logic [CODE_W-1:0]        r_pc;
    logic [ADDR_W-1:0]        r_bp;
    logic signed [TOP_W-1:0]  r_top;
    t_kind                    r_kind;
    logic [LEV_W-1:0]         r_cnt;
    logic [CODE_W-1:0]        r_opd;
    logic [ADDR_W-1:0]        r_lb;
    logic [WORD_W-1:0]        r_x;
    logic [WORD_W-1:0]        r_y;
    logic [WORD_W-1:0]        r_res;
    logic [1:0]               r_st;
    logic [ADDR_W-1:0]        r_clr;

    logic                     r_dbusy;
    logic [DCNT_W-1:0]        r_dcnt;
    logic [WORD_W-1:0]        r_dq;
    logic [WORD_W-1:0]        r_rem;
    logic [WORD_W-1:0]        r_mb;
    logic                     r_dneg;

    logic                     r_ovalid;
    logic [CODE_W-1:0]        r_o_pc;
    logic [ADDR_W-1:0]        r_o_bp;
    logic signed [TOP_W-1:0]  r_o_top;
    logic [WORD_W-1:0]        r_o_val;
    logic                     r_o_halt;
    logic [1:0]               r_o_st;

    logic [ADDR_W-1:0]        top_a;
    logic [ADDR_W:0]          lb_off;
    logic [ADDR_W-1:0]        addr;
    logic [WORD_W-1:0]        wdata;
    logic [CODE_W-1:0]        seq;
    logic signed [TOP_W:0]    int_sum;
    logic                     top_neg;
    logic                     top_full;
    logic [WORD_W-1:0]        alu;
    logic                     lt_yx;
    logic                     lt_xy;
    logic [WORD_W:0]          rem_sh;
    logic [WORD_W:0]          rem_sub;
    t_opr_cls                 cls;

    assign top_a    = r_top[ADDR_W-1:0];
    assign top_neg  = r_top[TOP_W-1];
    assign top_full = !top_neg && (&top_a);
    assign lb_off   = {1'b0, r_lb} + (ADDR_W+1)'(r_opd);
    assign seq      = r_pc + CODE_W'(1);
    assign int_sum  = (TOP_W+1)'(r_top) + $signed((TOP_W+1)'(r_opd));
    assign cls      = opr_class(r_opd);
    assign lt_yx    = $signed(r_y) < $signed(r_x);
    assign lt_xy    = $signed(r_x) < $signed(r_y);

    always_comb begin
        case (i_cmd.asel)
            A_TOP:      addr = top_a;
            A_TOP_M1:   addr = top_a - ADDR_W'(1);
            A_TOP_P1:   addr = top_a + ADDR_W'(1);
            A_TOP_P2:   addr = top_a + ADDR_W'(2);
            A_TOP_P3:   addr = top_a + ADDR_W'(3);
            A_LINK:     addr = r_lb;
            A_LINK_OFF: addr = lb_off[ADDR_W-1:0];
            A_BP_P1:    addr = r_bp + ADDR_W'(1);
            A_BP_P2:    addr = r_bp + ADDR_W'(2);
            A_CLR:      addr = r_clr;
            default:    addr = top_a;
        endcase
    end

    always_comb begin
        case (i_cmd.wsel)
            W_ZERO:  wdata = '0;
            W_OPD:   wdata = WORD_W'(r_opd);
            W_X:     wdata = r_x;
            W_RES:   wdata = r_res;
            W_LINK:  wdata = WORD_W'(r_lb);
            W_BP:    wdata = WORD_W'(r_bp);
            W_SEQ:   wdata = WORD_W'(seq);
            default: wdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[addr] <= wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rd <= mem[addr];
        end
    end

    // y is the lower stack word, x the top
    always_comb begin
        case (r_opd)
            OPR_NEG: alu = -r_x;
            OPR_ODD: alu = WORD_W'(r_x[0]);
            OPR_ADD: alu = r_y + r_x;
            OPR_SUB: alu = r_y - r_x;
            OPR_MUL: alu = r_y * r_x;
            OPR_EQ:  alu = WORD_W'(r_y == r_x);
            OPR_NE:  alu = WORD_W'(r_y != r_x);
            OPR_LT:  alu = WORD_W'(lt_yx);
            OPR_GE:  alu = WORD_W'(!lt_yx);
            OPR_GT:  alu = WORD_W'(lt_xy);
            OPR_LE:  alu = WORD_W'(!lt_xy);
            default: alu = '0;
        endcase
    end

    assign rem_sh  = {r_rem, r_dq[WORD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_mb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (i_cmd.exec && r_opd == OPR_DIV && r_x != '0) begin
            r_dbusy <= 1'b1;
        end else if (i_cmd.div_take) begin
            r_dbusy <= 1'b0;
        end
        if (i_cmd.exec) begin
            r_mb   <= r_x[WORD_W-1] ? -r_x : r_x;
            r_dq   <= r_y[WORD_W-1] ? -r_y : r_y;
            r_rem  <= '0;
            r_dcnt <= DCNT_W'(WORD_W);
            r_dneg <= r_x[WORD_W-1] ^ r_y[WORD_W-1];
        end else if (r_dbusy && r_dcnt != '0) begin
            r_dcnt <= r_dcnt - DCNT_W'(1);
            if (!rem_sub[WORD_W]) begin
                r_rem <= rem_sub[WORD_W-1:0];
                r_dq  <= {r_dq[WORD_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[WORD_W-1:0];
                r_dq  <= {r_dq[WORD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= '0;
            r_bp  <= '0;
            r_top <= '1;
            r_clr <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + ADDR_W'(1);
            if (i_cmd.fault) begin
                r_pc <= seq;
            end else if (i_cmd.commit) begin
                r_pc <= seq;
                case (r_kind)
                    K_LIT, K_LOD: r_top <= r_top + TOP_W'(1);
                    K_STO:        r_top <= r_top - TOP_W'(1);
                    K_OPR: begin
                        if (cls == OC_RET) begin
                            r_top <= $signed({1'b0, r_bp}) - TOP_W'(1);
                            r_bp  <= r_x[ADDR_W-1:0];
                            r_pc  <= r_y[CODE_W-1:0];
                        end else if (cls == OC_BINARY) begin
                            r_top <= r_top - TOP_W'(1);
                        end
                    end
                    K_CAL: begin
                        r_bp <= top_a + ADDR_W'(1);
                        r_pc <= r_opd;
                    end
                    K_INT: r_top <= int_sum[TOP_W-1:0];
                    K_JMP: r_pc  <= r_opd;
                    K_JPC: begin
                        r_top <= r_top - TOP_W'(1);
                        if (r_x == '0) r_pc <= r_opd;
                    end
                    default: r_pc <= seq;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= t_kind'(i_in.kind);
            r_cnt  <= i_in.level;
            r_opd  <= i_in.operand;
            r_lb   <= r_bp;
            r_st   <= STS_OK;
        end else begin
            if (i_cmd.link_step) begin
                r_lb  <= r_rd[ADDR_W-1:0];
                r_cnt <= r_cnt - LEV_W'(1);
            end
            if (i_cmd.fault) r_st <= STS_RANGE;
            if (i_cmd.exec && r_opd == OPR_DIV && r_x == '0) r_st <= STS_DIV0;
        end
        if (i_cmd.cap_x) r_x <= r_rd;
        if (i_cmd.cap_y) r_y <= r_rd;
        if (i_cmd.exec) begin
            r_res <= alu;
        end else if (i_cmd.div_take) begin
            r_res <= r_dneg ? -r_dq : r_dq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_o_pc   <= r_pc;
            r_o_bp   <= r_bp;
            r_o_top  <= r_top;
            r_o_val  <= top_neg ? '0 : r_rd;
            r_o_halt <= (r_pc == '0);
            r_o_st   <= r_st;
        end
    end

    assign i_in.ready      = i_cmd.in_ready;
    assign o_out.valid     = r_ovalid;
    assign o_out.next_pc   = r_o_pc;
    assign o_out.base_ptr  = r_o_bp;
    assign o_out.top_index = r_o_top;
    assign o_out.top_value = $signed(r_o_val);
    assign o_out.halted    = r_o_halt;
    assign o_out.status    = r_o_st;

    always_comb begin
        o_sts.in_valid = i_in.valid;
        o_sts.kind     = r_kind;
        o_sts.opd      = r_opd;
        o_sts.cnt_zero = (r_cnt == '0);
        o_sts.rd_bad   = (r_rd[WORD_W-1:ADDR_W] != '0);
        o_sts.addr_bad = lb_off[ADDR_W];
        o_sts.x_zero   = (r_x == '0);
        o_sts.div_done = r_dbusy && (r_dcnt == '0);
        o_sts.clr_last = &r_clr;
        o_sts.out_free = !r_ovalid || o_out.ready;
        o_sts.top_neg  = top_neg;
        case (r_kind)
            K_LIT, K_LOD: o_sts.pre_fault = top_full;
            K_OPR: begin
                case (cls)
                    OC_RET:    o_sts.pre_fault = (r_bp >= ADDR_W'(STACK_DEPTH - 2));
                    OC_UNARY:  o_sts.pre_fault = top_neg;
                    OC_BINARY: o_sts.pre_fault = top_neg || (r_top == '0);
                    default:   o_sts.pre_fault = 1'b0;
                endcase
            end
            K_STO, K_JPC: o_sts.pre_fault = top_neg;
            K_CAL:   o_sts.pre_fault = !top_neg && (top_a >= ADDR_W'(STACK_DEPTH - 3));
            K_INT:   o_sts.pre_fault = int_sum > $signed((TOP_W+1)'(STACK_DEPTH - 1));
            default: o_sts.pre_fault = 1'b0;
        endcase
    end

endmodule

FILE: rtl/pl0_pcode_stack_machine_unit.sv
// From acceptance to result: JMP and INT go straight to commit; loads, stores and calls
// first walk up to three levels of static link, and a nonzero divide runs one quotient bit a cycle.
// One item at a time runs through the single-port stack memory; a new item is accepted only
// after the last one's result is loaded. A finished result waits in the output register
// while the next item runs.
// Reset (synchronous, active low) clears PC, base and top, then sweeps the 4096-word stack
// to zero, during which no item is accepted.
module pl0_pcode_stack_machine_unit import pl0_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pl0_in_if.sink    i_in,
    pl0_out_if.source o_out
);

    t_cmd cmd;
    t_sts sts;

    pl0_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pl0_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("item accepted while previous still in flight");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.status != 2'd3)
        else $error("bad status code");

    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.halted == (o_out.next_pc == '0))
        else $error("halt flag disagrees with pc");

    a_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!o_out.top_index[TOP_W-1] || (&o_out.top_index)))
        else $error("top index below empty");

    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_take |-> sts.kind == K_OPR && sts.opd == OPR_DIV)
        else $error("divider result taken outside divide");

endmodule

FILE: sim/pl0_pcode_stack_machine_unit_tb.sv
module pl0_pcode_stack_machine_unit_tb;
    import pl0_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0]        next_pc;
        logic [ADDR_W-1:0]        base_ptr;
        logic signed [TOP_W-1:0]  top_index;
        logic signed [WORD_W-1:0] top_value;
        logic                     halted;
        logic [1:0]               status;
    } t_step_res;

    logic i_clk;
    logic i_rst_n;

    pl0_in_if  in_ch ();
    pl0_out_if out_ch ();

    pl0_pcode_stack_machine_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    logic [WORD_W-1:0] mach_stack [STACK_DEPTH];
    logic [CODE_W-1:0] mach_pc;
    logic [ADDR_W-1:0] mach_bp;
    int                mach_top;

    t_step_res expected_q[$];
    int        n_errors;
    int        n_sent;
    int        n_checked;
    int        n_div0;
    int        n_range;
    int        n_halts;
    bit        hold_off;
    bit        stall_on;

    initial begin
        i_clk = 1'b0;
        forever begin
            #2 i_clk = 1'b1;
            #2 i_clk = 1'b0;
        end
    end

    function automatic bit is_index(logic [WORD_W-1:0] w);
        return !w[WORD_W-1] && w < STACK_DEPTH;
    endfunction

    function automatic bit walk_links(int lev, output int base);
        int b1;
        b1 = mach_bp;
        for (int k = 0; k < lev; k++) begin
            if (!is_index(mach_stack[b1])) return 1'b0;
            b1 = mach_stack[b1];
        end
        base = b1;
        return 1'b1;
    endfunction

    function automatic logic [WORD_W-1:0] quotient(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] ma, mb, q;
        ma = a[WORD_W-1] ? -a : a;
        mb = b[WORD_W-1] ? -b : b;
        q  = ma / mb;
        return (a[WORD_W-1] != b[WORD_W-1]) ? -q : q;
    endfunction

    function automatic t_step_res exec_instr(t_kind kind, int lev, logic [CODE_W-1:0] opd);
        t_step_res res;
        int t, lb, addr;
        logic [ADDR_W-1:0] b;
        logic [CODE_W-1:0] seq, p;
        logic [WORD_W-1:0] x, y, r;
        logic [1:0] st;
        bit fault;
        t = mach_top;
        b = mach_bp;
        seq = mach_pc + 1'b1;
        p = seq;
        st = STS_OK;
        fault = 1'b0;
        lb = 0;
        case (kind)
            K_LIT: begin
                if (t + 1 >= STACK_DEPTH) fault = 1'b1;
                else begin
                    t++;
                    mach_stack[t] = WORD_W'(opd);
                end
            end
            K_OPR: begin
                if (opd == OPR_RET) begin
                    if (b + 2 >= STACK_DEPTH || !is_index(mach_stack[b + 1])) fault = 1'b1;
                    else begin
                        t = int'(b) - 1;
                        p = mach_stack[b + 2][CODE_W-1:0];
                        b = mach_stack[b + 1][ADDR_W-1:0];
                    end
                end else if (opd == OPR_NEG || opd == OPR_ODD) begin
                    if (t < 0) fault = 1'b1;
                    else if (opd == OPR_NEG) mach_stack[t] = -mach_stack[t];
                    else mach_stack[t] = {31'd0, mach_stack[t][0]};
                end else if ((opd >= OPR_ADD && opd <= OPR_DIV) ||
                             (opd >= OPR_EQ && opd <= OPR_LE)) begin
                    if (t < 1) fault = 1'b1;
                    else begin
                        x = mach_stack[t - 1];
                        y = mach_stack[t];
                        case (opd)
                            OPR_ADD: r = x + y;
                            OPR_SUB: r = x - y;
                            OPR_MUL: r = x * y;
                            OPR_DIV: begin
                                if (y == 0) begin
                                    r = '0;
                                    st = STS_DIV0;
                                end else begin
                                    r = quotient(x, y);
                                end
                            end
                            OPR_EQ:  r = WORD_W'(x == y);
                            OPR_NE:  r = WORD_W'(x != y);
                            OPR_LT:  r = WORD_W'($signed(x) < $signed(y));
                            OPR_GE:  r = WORD_W'($signed(x) >= $signed(y));
                            OPR_GT:  r = WORD_W'($signed(x) > $signed(y));
                            default: r = WORD_W'($signed(x) <= $signed(y));
                        endcase
                        t--;
                        mach_stack[t] = r;
                    end
                end
            end
            K_LOD: begin
                if (!walk_links(lev, lb)) fault = 1'b1;
                else begin
                    addr = lb + opd;
                    if (addr >= STACK_DEPTH || t + 1 >= STACK_DEPTH) fault = 1'b1;
                    else begin
                        t++;
                        mach_stack[t] = mach_stack[addr];
                    end
                end
            end
            K_STO: begin
                if (t < 0 || !walk_links(lev, lb)) fault = 1'b1;
                else begin
                    addr = lb + opd;
                    if (addr >= STACK_DEPTH) fault = 1'b1;
                    else begin
                        mach_stack[addr] = mach_stack[t];
                        t--;
                    end
                end
            end
            K_CAL: begin
                if (!walk_links(lev, lb) || t + 3 >= STACK_DEPTH) fault = 1'b1;
                else begin
                    mach_stack[t + 1] = WORD_W'(lb);
                    mach_stack[t + 2] = WORD_W'(b);
                    mach_stack[t + 3] = WORD_W'(p);
                    b = ADDR_W'(t + 1);
                    p = opd;
                end
            end
            K_INT: begin
                if (t + int'(opd) >= STACK_DEPTH) fault = 1'b1;
                else t += int'(opd);
            end
            K_JMP: p = opd;
            default: begin
                if (t < 0) fault = 1'b1;
                else begin
                    if (mach_stack[t] == 0) p = opd;
                    t--;
                end
            end
        endcase
        if (fault) begin
            st = STS_RANGE;
            p = seq;
        end else begin
            mach_top = t;
            mach_bp = b;
        end
        mach_pc = p;
        res.next_pc   = mach_pc;
        res.base_ptr  = mach_bp;
        res.top_index = TOP_W'(mach_top);
        res.top_value = (mach_top >= 0) ? mach_stack[mach_top] : '0;
        res.halted    = (mach_pc == 0);
        res.status    = st;
        return res;
    endfunction

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
        if (!stall_on) n = 0;
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_instr(t_kind kind, int lev, int opd);
        t_step_res e;
        idle_gap();
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= kind;
        in_ch.level   <= LEV_W'(lev);
        in_ch.operand <= CODE_W'(opd);
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        e = exec_instr(kind, lev, CODE_W'(opd));
        expected_q.push_back(e);
        n_sent++;
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic int rand_opd();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 2047;
            default: return $urandom_range(0, 2047);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_step_res e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, out_ch.next_pc);
                n_errors++;
            end else begin
                e = expected_q.pop_front();
                n_checked++;
                if (e.status == STS_DIV0) n_div0++;
                if (e.status == STS_RANGE) n_range++;
                if (e.halted) n_halts++;
                if (out_ch.next_pc !== e.next_pc) begin
                    $display("%0t: next_pc exp %0d got %0d", $time, e.next_pc, out_ch.next_pc);
                    n_errors++;
                end
                if (out_ch.base_ptr !== e.base_ptr) begin
                    $display("%0t: base_ptr exp %0d got %0d", $time, e.base_ptr,
                             out_ch.base_ptr);
                    n_errors++;
                end
                if (out_ch.top_index !== e.top_index) begin
                    $display("%0t: top_index exp %0d got %0d", $time, e.top_index,
                             out_ch.top_index);
                    n_errors++;
                end
                if (out_ch.top_value !== e.top_value) begin
                    $display("%0t: top_value exp %0d got %0d", $time, e.top_value,
                             out_ch.top_value);
                    n_errors++;
                end
                if (out_ch.halted !== e.halted) begin
                    $display("%0t: halted exp %0b got %0b", $time, e.halted, out_ch.halted);
                    n_errors++;
                end
                if (out_ch.status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, out_ch.status);
                    n_errors++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (hold_off) out_ch.ready <= 1'b0;
        else if (!stall_on) out_ch.ready <= 1'b1;
        else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic test_directed();
        send_instr(K_OPR, 0, OPR_NEG);
        send_instr(K_JPC, 0, 5);
        send_instr(K_STO, 0, 0);
        send_instr(K_LIT, 0, 2047);
        send_instr(K_LIT, 0, 0);
        send_instr(K_OPR, 0, OPR_DIV);
        send_instr(K_LIT, 0, 7);
        send_instr(K_OPR, 0, OPR_NEG);
        send_instr(K_OPR, 0, OPR_ODD);
        send_instr(K_LIT, 0, 1);
        send_instr(K_OPR, 0, OPR_SUB);
        send_instr(K_LIT, 0, 1);
        for (int f = OPR_ADD; f <= OPR_LE; f++) begin
            send_instr(K_LIT, 0, $urandom_range(0, 2047));
            send_instr(K_OPR, 0, f);
        end
        send_instr(K_INT, 0, 2047);
        send_instr(K_INT, 0, 2047);
        send_instr(K_INT, 0, 2047);
        send_instr(K_LOD, 3, 2047);
        send_instr(K_CAL, 3, 2047);
        send_instr(K_JMP, 0, 0);
        send_instr(K_JPC, 0, 2047);
        wait_drain();
    endtask

    // random mix of literals, frames, calls, stores, loads, operations, jumps and returns
    task automatic test_programs(int count);
        int k;
        k = 0;
        while (k < count) begin
            if (mach_top > 3000) begin
                send_instr(K_OPR, 0, OPR_RET);
                send_instr(K_INT, 0, 0);
                k += 2;
                continue;
            end
            case ($urandom_range(0, 15))
                0, 1: send_instr(K_LIT, 0, rand_opd());
                2:    send_instr(K_CAL, $urandom_range(0, 3), $urandom_range(0, 2047));
                3:    send_instr(K_INT, 0, $urandom_range(3, 8));
                4, 5: send_instr(K_LOD, $urandom_range(0, 3), $urandom_range(0, 10));
                6:    send_instr(K_STO, $urandom_range(0, 3), $urandom_range(0, 10));
                7, 8, 9: send_instr(K_OPR, 0, $urandom_range(0, 13));
                10:   send_instr(K_OPR, 0, rand_opd());
                11:   send_instr(K_JPC, 0, rand_opd());
                12:   send_instr(K_JMP, 0, rand_opd());
                13:   send_instr(K_OPR, 0, OPR_RET);
                14:   send_instr(K_LOD, 0, rand_opd());
                default: send_instr(t_kind'($urandom_range(0, 7)), $urandom_range(0, 3),
                                    rand_opd());
            endcase
            k++;
        end
        wait_drain();
    endtask

    task automatic test_full_stall();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 10; k++) send_instr(K_LIT, 0, $urandom_range(0, 2047));
        join
        wait_drain();
    endtask

    initial begin
        for (int k = 0; k < STACK_DEPTH; k++) mach_stack[k] = '0;
        mach_pc = '0;
        mach_bp = '0;
        mach_top = -1;
        n_errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_div0 = 0;
        n_range = 0;
        n_halts = 0;
        hold_off = 1'b0;
        stall_on = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind = '0;
        in_ch.level = '0;
        in_ch.operand = '0;
        out_ch.ready = 1'b1;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        stall_on = 1'b1;
        test_programs(400);
        test_full_stall();
        stall_on = 1'b0;
        test_programs(150);
        stall_on = 1'b1;
        test_programs(270);
        repeat (100) @(posedge i_clk);
        $display("%0d items sent, %0d results checked", n_sent, n_checked);
        $display("%0d divide-by-zero, %0d range faults, %0d halts", n_div0, n_range, n_halts);
        if (n_errors == 0) $display("pl0_pcode_stack_machine_unit_tb OK");
        else $display("pl0_pcode_stack_machine_unit_tb NOT OK");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("pl0_pcode_stack_machine_unit_tb NOT OK");
        $finish;
    end

endmodule
